[hdl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// Used by rau_reduce and rational_arithmetic_unit_core; no dependencies.
package rau_pkg;

  localparam int FIELD_W  = 16;
  localparam int FUNC_W   = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 4'd0,
    FN_SUB = 4'd1,
    FN_MUL = 4'd2,
    FN_DIV = 4'd3,
    FN_EQ  = 4'd4,
    FN_NE  = 4'd5,
    FN_LT  = 4'd6,
    FN_GT  = 4'd7,
    FN_LE  = 4'd8,
    FN_GE  = 4'd9
  } rau_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2
  } rau_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_RED,
    S_WAIT,
    S_FIN
  } rau_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_TZ,
    U_GCD,
    U_DIVN,
    U_DIVD,
    U_DONE
  } rau_unit_state_e;

endpackage

[hdl/rau_reduce.sv]
// Iterative fraction reducer: binary GCD followed by two restoring divisions,
// all on one shared subtractor. Depends on rau_pkg.
module rau_reduce #(
  parameter int PW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] n_i,
  input  logic [PW-1:0] d_i,
  output logic          done_o,
  output logic [PW-1:0] qn_o,
  output logic [PW-1:0] qd_o
);
  import rau_pkg::*;

  localparam int SW   = PW + 1;
  localparam int CNTW = $clog2(PW);

  rau_unit_state_e state_q, state_d;

  logic [PW-1:0]   u_q, u_d, v_q, v_d, nk_q, nk_d, dk_q, dk_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  // The shared subtractor.
  logic [SW-1:0] sub_a, sub_b;
  logic [SW:0]   diff;
  logic          borrow;
  logic [PW-1:0] shreg;

  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[SW];
  assign shreg  = (state_q == U_DIVD) ? dk_q : nk_q;

  always_comb begin
    if (state_q == U_DIVN || state_q == U_DIVD) begin
      sub_a = {u_q, shreg[PW-1]};
    end else begin
      sub_a = {1'b0, u_q};
    end
    sub_b = {1'b0, v_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    nk_q  <= nk_d;
    dk_q  <= dk_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d = state_q;
    u_d     = u_q;
    v_d     = v_q;
    nk_d    = nk_q;
    dk_d    = dk_q;
    cnt_d   = cnt_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          u_d     = n_i;
          v_d     = d_i;
          state_d = U_TZ;
        end
      end
      U_TZ: begin
        // Strip the factors of two common to both; the stripped values are
        // the dividends of the final divisions.
        if (u_q[0] || v_q[0]) begin
          nk_d    = u_q;
          dk_d    = v_q;
          state_d = U_GCD;
        end else begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
        end
      end
      U_GCD: begin
        if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (diff == '0) begin
          // v now holds the odd divisor; u becomes the remainder.
          u_d     = '0;
          cnt_d   = '0;
          state_d = U_DIVN;
        end else if (borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = {1'b0, diff[PW-1:1]};
        end
      end
      U_DIVN, U_DIVD: begin
        if (borrow) begin
          u_d = sub_a[PW-1:0];
        end else begin
          u_d = diff[PW-1:0];
        end
        if (state_q == U_DIVN) begin
          nk_d = {nk_q[PW-2:0], ~borrow};
        end else begin
          dk_d = {dk_q[PW-2:0], ~borrow};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(PW - 1)) begin
          cnt_d = '0;
          if (state_q == U_DIVN) begin
            u_d     = '0;
            state_d = U_DIVD;
          end else begin
            state_d = U_DONE;
          end
        end
      end
      U_DONE: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == U_DONE);
  assign qn_o   = nk_q;
  assign qd_o   = dk_q;

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == U_GCD |-> (u_q != '0) && (v_q != '0))
    else $error("GCD operand reached zero");

  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == U_DIVN || state_q == U_DIVD) |-> v_q[0])
    else $error("divisor is not odd");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == U_DIVN || state_q == U_DIVD) |-> u_q < v_q)
    else $error("remainder not below divisor");

endmodule

[hdl/rational_arithmetic_unit_core.sv]
// Top level of the rational arithmetic unit: operand capture, shared
// multiplier, sequencer and output register. Depends on rau_pkg, rau_reduce.
//
// One transaction carries two sign-magnitude fractions and an operation code
// and yields exactly one result transaction. The block works on one
// transaction at a time: in_stall_o is high from acceptance until the result
// has been handed to the output register, which may still be waiting on the
// downstream side while the next transaction is accepted. The three cross
// products are formed one per cycle on a single WIDTH-limited multiplier.
// Compare operations, zero-denominator errors and unused codes go from the SUM
// step to the FIN step, zero results pass through the RED step first, and the
// next transaction can be accepted in the cycle after the output register is
// loaded. Nonzero add, subtract, multiply and divide results are reduced by
// rau_reduce, whose single subtractor runs a binary GCD (up to about two steps
// per bit of the two 2*EW+1 bit operands, EW being the smaller of WIDTH and 16)
// and then two restoring divisions of 2*EW+1 steps each. Operands are taken
// modulo 2^EW, and a reduced result that does not fit EW bits is reported as
// overflow.
module rational_arithmetic_unit_core #(
  parameter int WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rau_pkg::FUNC_W-1:0]    func_i,
  input  logic [rau_pkg::FIELD_W-1:0]   a_num_i,
  input  logic [rau_pkg::FIELD_W-1:0]   a_den_i,
  input  logic                          a_neg_i,
  input  logic [rau_pkg::FIELD_W-1:0]   b_num_i,
  input  logic [rau_pkg::FIELD_W-1:0]   b_den_i,
  input  logic                          b_neg_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rau_pkg::FIELD_W-1:0]   r_num_o,
  output logic [rau_pkg::FIELD_W-1:0]   r_den_o,
  output logic                          r_neg_o,
  output logic                          cmp_true_o,
  output logic [rau_pkg::STATUS_W-1:0]  status_o
);
  import rau_pkg::*;

  // Effective operand width: the fields are 16 bits, WIDTH may narrow them.
  localparam int EW  = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
  localparam int PRW = 2 * EW;
  localparam int PW  = PRW + 1;
  localparam logic [PW-1:0] LIMIT = PW'((1 << EW) - 1);

  rau_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept, out_load;

  // Captured operands, masked to EW bits.
  logic [FUNC_W-1:0] func_q;
  logic [EW-1:0]     an_q, ad_q, bn_q, bd_q;
  logic              ang_q, bng_q;

  // Products, the unreduced fraction and its sign.
  logic [PRW-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic [PW-1:0]  n_q, n_d, d_q, d_d;
  logic           neg_q, neg_d;

  // Result waiting for the output register.
  logic [FIELD_W-1:0]  pnum_q, pnum_d, pden_q, pden_d;
  logic                pneg_q, pneg_d, pcmp_q, pcmp_d;
  logic [STATUS_W-1:0] pst_q, pst_d;

  // Shared multiplier.
  logic [EW-1:0]  mul_a, mul_b;
  logic [PRW-1:0] mul_p;

  // Reducer interface.
  logic          red_start, red_done;
  logic [PW-1:0] red_qn, red_qd;

  // Arithmetic and compare terms, used in the SUM step.
  logic [PW-1:0] x_e, y_e;
  logic          bs, sl, sr, lt_v, eq_v, raw_eq, zero_den;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (state_q)
      S_MUL0: begin
        mul_a = an_q;
        mul_b = (func_q == FN_MUL) ? bn_q : bd_q;
      end
      S_MUL1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      S_MUL2: begin
        mul_a = ad_q;
        mul_b = (func_q == FN_DIV) ? bn_q : bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign x_e      = PW'(p0_q);
  assign y_e      = PW'(p1_q);
  assign bs       = (func_q == FN_SUB) ? !bng_q : bng_q;
  // Negative zero orders as zero.
  assign sl       = ang_q && (p0_q != '0);
  assign sr       = bng_q && (p1_q != '0);
  assign eq_v     = (p0_q == p1_q) && (sl == sr);
  assign lt_v     = (sl != sr) ? sl : (sl ? (p0_q > p1_q) : (p0_q < p1_q));
  assign raw_eq   = (an_q == bn_q) && (ad_q == bd_q) && (ang_q == bng_q);
  assign zero_den = (ad_q == '0) || (bd_q == '0) || ((func_q == FN_DIV) && (bn_q == '0));

  always_comb begin
    state_d   = state_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    n_d       = n_q;
    d_d       = d_q;
    neg_d     = neg_q;
    pnum_d    = pnum_q;
    pden_d    = pden_q;
    pneg_d    = pneg_q;
    pcmp_d    = pcmp_q;
    pst_d     = pst_q;
    red_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        p0_d    = mul_p;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        p1_d    = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p2_d    = mul_p;
        state_d = S_SUM;
      end
      S_SUM: begin
        pnum_d  = '0;
        pden_d  = '0;
        pneg_d  = 1'b0;
        pcmp_d  = 1'b0;
        pst_d   = ST_OK;
        state_d = S_FIN;
        if (func_q > FN_GE) begin
          // Unused codes give an all-zero result.
          pst_d = ST_OK;
        end else if (zero_den) begin
          pst_d = ST_ZDEN;
        end else if (func_q >= FN_EQ) begin
          case (func_q)
            FN_EQ:   pcmp_d = raw_eq;
            FN_NE:   pcmp_d = !raw_eq;
            FN_LT:   pcmp_d = lt_v;
            FN_GT:   pcmp_d = !lt_v && !eq_v;
            FN_LE:   pcmp_d = lt_v || eq_v;
            FN_GE:   pcmp_d = !lt_v;
            default: pcmp_d = 1'b0;
          endcase
        end else begin
          d_d     = PW'(p2_q);
          state_d = S_RED;
          if (func_q == FN_MUL || func_q == FN_DIV) begin
            n_d   = x_e;
            neg_d = ang_q != bng_q;
          end else if (ang_q == bs) begin
            n_d   = x_e + y_e;
            neg_d = ang_q;
          end else if (p0_q >= p1_q) begin
            n_d   = x_e - y_e;
            neg_d = ang_q;
          end else begin
            n_d   = y_e - x_e;
            neg_d = bs;
          end
        end
      end
      S_RED: begin
        if (n_q == '0) begin
          // A zero result is always written as positive 0/1.
          pnum_d  = '0;
          pden_d  = FIELD_W'(1);
          pneg_d  = 1'b0;
          pcmp_d  = 1'b0;
          pst_d   = ST_OK;
          state_d = S_FIN;
        end else begin
          red_start = 1'b1;
          state_d   = S_WAIT;
        end
      end
      S_WAIT: begin
        if (red_done) begin
          pcmp_d  = 1'b0;
          state_d = S_FIN;
          if (red_qn > LIMIT || red_qd > LIMIT) begin
            pnum_d = '0;
            pden_d = '0;
            pneg_d = 1'b0;
            pst_d  = ST_OVF;
          end else begin
            pnum_d = FIELD_W'(red_qn);
            pden_d = FIELD_W'(red_qd);
            pneg_d = neg_q;
            pst_d  = ST_OK;
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      an_q   <= a_num_i[EW-1:0];
      ad_q   <= a_den_i[EW-1:0];
      ang_q  <= a_neg_i;
      bn_q   <= b_num_i[EW-1:0];
      bd_q   <= b_den_i[EW-1:0];
      bng_q  <= b_neg_i;
    end
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    n_q    <= n_d;
    d_q    <= d_d;
    neg_q  <= neg_d;
    pnum_q <= pnum_d;
    pden_q <= pden_d;
    pneg_q <= pneg_d;
    pcmp_q <= pcmp_d;
    pst_q  <= pst_d;
    if (out_load) begin
      r_num_o    <= pnum_q;
      r_den_o    <= pden_q;
      r_neg_o    <= pneg_q;
      cmp_true_o <= pcmp_q;
      status_o   <= pst_q;
    end
  end

  assign out_valid_o = out_valid_q;

  rau_reduce #(
    .PW(PW)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .n_i     (n_q),
    .d_i     (d_q),
    .done_o  (red_done),
    .qn_o    (red_qn),
    .qd_o    (red_qd)
  );

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> state_q == S_WAIT)
    else $error("reducer finished outside the wait step");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (r_num_o == '0) && (r_den_o == '0) && !r_neg_o && !cmp_true_o)
    else $error("error result carries a value");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmp_true_o |-> (r_den_o == '0) && (status_o == ST_OK))
    else $error("compare result carries a fraction");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("output register overwritten while stalled");

endmodule

[tb/tb_rational_arithmetic_unit_core.sv]
// Self-checking testbench for rational_arithmetic_unit_core with its own fraction predictor.
// Depends on rau_pkg and the RTL of the rational arithmetic unit; reads no files.
module tb_rational_arithmetic_unit_core;
  import rau_pkg::*;

  // The block is built at its default width. The predictor follows the same value.
  localparam int WIDTH = 16;

  // Function codes 10 to 15 have no name in the package. They must give all-zero outputs.
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd10;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int TAIL_ITEMS     = 150;   // the final stretch runs with no idling on either side
  localparam int LONG_HOLD_AT   = 300;   // result count at which the receiver holds off
  localparam int LONG_HOLD_LEN  = 400;   // length of that hold-off in cycles
  localparam int DRAIN_AT       = 800;   // random item that waits until all results are back
  localparam int SETTLE_CYCLES  = 300;   // quiet cycles after the last result, to catch extras
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] a_num;
    logic [FIELD_W-1:0] a_den;
    logic               a_neg;
    logic [FIELD_W-1:0] b_num;
    logic [FIELD_W-1:0] b_den;
    logic               b_neg;
    logic               drain_first;
  } operand_pair_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  num;
    logic [FIELD_W-1:0]  den;
    logic                neg;
    logic                cmp;
    logic [STATUS_W-1:0] status;
  } fraction_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   in_func  = '0;
  logic [FIELD_W-1:0]  in_a_num = '0;
  logic [FIELD_W-1:0]  in_a_den = '0;
  logic                in_a_neg = 1'b0;
  logic [FIELD_W-1:0]  in_b_num = '0;
  logic [FIELD_W-1:0]  in_b_den = '0;
  logic                in_b_neg = 1'b0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic [FIELD_W-1:0]  r_num_o;
  logic [FIELD_W-1:0]  r_den_o;
  logic                r_neg_o;
  logic                cmp_true_o;
  logic [STATUS_W-1:0] status_o;

  // The queue of operand pairs that the driver has not yet offered, and the queue of
  // predicted fractions that the monitor compares each result transaction against.
  operand_pair_t    operand_pairs[$];
  fraction_result_t predicted_fractions[$];

  int unsigned n_items    = 0;
  int unsigned sent_cnt   = 0;
  int unsigned rcvd_cnt   = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned idle_cycles = 0;
  logic        long_hold_done = 1'b0;

  rational_arithmetic_unit_core #(
    .WIDTH(WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .func_i     (in_func),
    .a_num_i    (in_a_num),
    .a_den_i    (in_a_den),
    .a_neg_i    (in_a_neg),
    .b_num_i    (in_b_num),
    .b_den_i    (in_b_den),
    .b_neg_i    (in_b_neg),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .r_num_o    (r_num_o),
    .r_den_o    (r_den_o),
    .r_neg_o    (r_neg_o),
    .cmp_true_o (cmp_true_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the fraction, or the comparison flag, that one operand pair must yield.
  // Sums and products are formed exactly at 64 bits and then reduced by Euclid's GCD.
  // Anything that does not fit the effective width after reduction counts as overflow.
  function automatic fraction_result_t rational_op_result(input operand_pair_t op);
    fraction_result_t res;
    logic [63:0] wmask, limit, an, ad, bn, bd, x, y, n, d, t;
    logic        neg, b_sign, flag;
    longint      lhs, rhs;
    res    = '0;
    neg    = 1'b0;
    flag   = 1'b0;
    wmask  = (WIDTH >= 64) ? '1 : (64'd1 << WIDTH) - 64'd1;
    limit  = (64'd1 << ((WIDTH < FIELD_W) ? WIDTH : FIELD_W)) - 64'd1;
    an = 64'(op.a_num) & wmask;
    ad = 64'(op.a_den) & wmask;
    bn = 64'(op.b_num) & wmask;
    bd = 64'(op.b_den) & wmask;
    if (op.func > FN_GE) return res;
    if (ad == 0 || bd == 0 || (op.func == FN_DIV && bn == 0)) begin
      res.status = ST_ZDEN;
      return res;
    end
    if (op.func >= FN_EQ) begin
      // Equality works on the raw fields. Ordering compares the cross products as signed values,
      // so a negative zero is equal to zero there.
      if (op.func == FN_EQ || op.func == FN_NE) begin
        flag = (an == bn) && (ad == bd) && (op.a_neg == op.b_neg);
        if (op.func == FN_NE) flag = !flag;
      end else begin
        lhs = longint'(an * bd);
        rhs = longint'(bn * ad);
        if (op.a_neg) lhs = -lhs;
        if (op.b_neg) rhs = -rhs;
        case (op.func)
          FN_LT:   flag = lhs < rhs;
          FN_GT:   flag = lhs > rhs;
          FN_LE:   flag = lhs <= rhs;
          default: flag = lhs >= rhs;
        endcase
      end
      res.cmp = flag;
      return res;
    end
    case (op.func)
      FN_ADD, FN_SUB: begin
        b_sign = (op.func == FN_SUB) ? !op.b_neg : op.b_neg;
        x = an * bd;
        y = bn * ad;
        d = ad * bd;
        if (op.a_neg == b_sign) begin
          n   = x + y;
          neg = op.a_neg;
        end else if (x >= y) begin
          n   = x - y;
          neg = op.a_neg;
        end else begin
          n   = y - x;
          neg = b_sign;
        end
      end
      FN_MUL: begin
        n   = an * bn;
        d   = ad * bd;
        neg = op.a_neg != op.b_neg;
      end
      default: begin
        n   = an * bd;
        d   = ad * bn;
        neg = op.a_neg != op.b_neg;
      end
    endcase
    if (n == 0) begin
      d   = 64'd1;
      neg = 1'b0;
    end else begin
      x = n;
      y = d;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      n = n / x;
      d = d / x;
    end
    if (n > limit || d > limit) begin
      res.status = ST_OVF;
      return res;
    end
    res.num    = n[FIELD_W-1:0];
    res.den    = d[FIELD_W-1:0];
    res.neg    = neg;
    res.status = ST_OK;
    return res;
  endfunction

  // Magnitudes are often small, so that many sums and products survive reduction.
  // Some are mid-range or full-range, and now and then one is an extreme.
  function automatic logic [FIELD_W-1:0] pick_magnitude(input bit nonzero);
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = FIELD_W'($urandom_range(0, 15));
      4, 5:       v = FIELD_W'($urandom_range(0, 255));
      6, 7, 8:    v = FIELD_W'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = FIELD_W'(1);
          2:       v = '1;
          default: v = FIELD_W'(16'h8000);
        endcase
      end
    endcase
    if (nonzero && v == 0) v = FIELD_W'($urandom_range(1, 65535));
    return v;
  endfunction

  task automatic add_operands(input logic [FUNC_W-1:0] func,
                              input int an, input int ad, input logic aneg,
                              input int bn, input int bd, input logic bneg);
    operand_pairs.push_back('{func, FIELD_W'(an), FIELD_W'(ad), aneg,
                              FIELD_W'(bn), FIELD_W'(bd), bneg, 1'b0});
  endtask

  // Idling is allowed in two phases out of every three. There is none in the tail of the run.
  function automatic bit idling_allowed(input int unsigned count);
    return (count + TAIL_ITEMS < n_items) && ((count / 100) % 3 != 0);
  endfunction

  // The driver offers the oldest pending pair. It holds the payload steady while the block stalls.
  // After a transaction it may leave a random gap. A pair marked drain_first is not offered
  // until every earlier result has come back.
  always @(posedge clk_i or negedge rst_ni) begin : operand_driver
    logic        taken;
    int unsigned issued;
    operand_pair_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      sent_cnt <= 0;
    end else begin
      taken  = in_valid && !in_stall_o;
      issued = sent_cnt + (taken ? 1 : 0);
      if (taken) sent_cnt <= issued;
      if (in_valid && !taken) begin
        // Stalled: the payload stays where it is.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (taken && idling_allowed(issued) && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (operand_pairs.size() != 0 &&
                   (!operand_pairs[0].drain_first || issued == rcvd_cnt)) begin
        nxt = operand_pairs.pop_front();
        in_func  <= nxt.func;
        in_a_num <= nxt.a_num;
        in_a_den <= nxt.a_den;
        in_a_neg <= nxt.a_neg;
        in_b_num <= nxt.b_num;
        in_b_den <= nxt.b_den;
        in_b_neg <= nxt.b_neg;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls in short random bursts. Once in the run it holds off for a long stretch,
  // so that the output register fills and the block has to stall its input side as well.
  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    if (!rst_ni) begin
      out_stall      <= 1'b0;
      stall_left     <= 0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && rcvd_cnt >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_LEN - 1;
      out_stall      <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling_allowed(rcvd_cnt) && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // The monitor checks each result transaction against the oldest prediction, field by field.
  // It then records the prediction for any operand transaction taken at the same edge.
  // A result never leaves in the same cycle as its operands, so this order is safe.
  // The watchdog also lives here: it counts cycles in which neither side moves a transaction.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    fraction_result_t exp_res;
    logic             moved;
    if (!rst_ni) begin
      rcvd_cnt    <= 0;
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (out_valid_o && !out_stall) begin
        moved = 1'b1;
        rcvd_cnt <= rcvd_cnt + 1;
        if (predicted_fractions.size() == 0) begin
          $display("%0t: result transaction with none expected, %s %0d/%0d neg %0b cmp %0b st %0d",
                   $time, "actual", r_num_o, r_den_o, r_neg_o, cmp_true_o, status_o);
          mismatches++;
        end else begin
          exp_res = predicted_fractions.pop_front();
          check_field("r_num", 32'(exp_res.num), 32'(r_num_o));
          check_field("r_den", 32'(exp_res.den), 32'(r_den_o));
          check_field("r_neg", 32'(exp_res.neg), 32'(r_neg_o));
          check_field("cmp_true", 32'(exp_res.cmp), 32'(cmp_true_o));
          check_field("status", 32'(exp_res.status), 32'(status_o));
        end
      end
      if (in_valid && !in_stall_o) begin
        moved = 1'b1;
        predicted_fractions.push_back(rational_op_result('{in_func, in_a_num, in_a_den, in_a_neg,
                                                           in_b_num, in_b_den, in_b_neg, 1'b0}));
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Fills the stimulus queue, applies reset once and waits for every result. After a quiet
  // settling period it gives the verdict.
  initial begin : run_control
    operand_pair_t op;
    int            r;
    // Directed: every operation and each special case, with the field extremes among them.
    add_operands(FN_ADD, 1, 2, 1'b0, 1, 3, 1'b0);
    add_operands(FN_SUB, 1, 2, 1'b0, 1, 3, 1'b0);
    add_operands(FN_SUB, 1, 3, 1'b0, 1, 2, 1'b0);
    add_operands(FN_MUL, 3, 4, 1'b1, 2, 9, 1'b0);
    add_operands(FN_DIV, 3, 4, 1'b0, 9, 8, 1'b1);
    add_operands(FN_EQ, 5, 7, 1'b0, 5, 7, 1'b0);
    add_operands(FN_EQ, 0, 1, 1'b1, 0, 1, 1'b0);      // negative zero is not equal to zero
    add_operands(FN_NE, 0, 1, 1'b1, 0, 1, 1'b0);
    add_operands(FN_LT, 0, 1, 1'b1, 0, 1, 1'b0);      // ordering treats both zeros as equal
    add_operands(FN_LE, 0, 1, 1'b1, 0, 3, 1'b0);
    add_operands(FN_GT, 65535, 1, 1'b0, 1, 65535, 1'b0);
    add_operands(FN_GE, 1, 1, 1'b1, 1, 2, 1'b1);
    add_operands(FN_ADD, 1, 2, 1'b0, 1, 2, 1'b1);     // zero result, given as 0/1 and positive
    add_operands(FN_MUL, 0, 5, 1'b1, 3, 7, 1'b1);
    add_operands(FN_ADD, 1, 0, 1'b0, 1, 3, 1'b0);     // zero denominator on a
    add_operands(FN_LT, 1, 2, 1'b0, 1, 0, 1'b1);      // zero denominator on b
    add_operands(FN_DIV, 3, 4, 1'b0, 0, 5, 1'b0);     // division by a zero fraction
    add_operands(FN_MUL, 65535, 1, 1'b0, 65535, 1, 1'b1);      // numerator overflow
    add_operands(FN_ADD, 1, 65535, 1'b0, 1, 65534, 1'b0);      // denominator overflow
    add_operands(FN_SUB, 65535, 1, 1'b0, 65535, 1, 1'b1);
    add_operands(FN_DIV, 65535, 65535, 1'b1, 65535, 65535, 1'b1);
    add_operands(FN_UNUSED_LO, 1, 2, 1'b0, 1, 3, 1'b0);
    add_operands(FN_UNUSED_HI, 65535, 65535, 1'b1, 65535, 65535, 1'b1);
    // Random: mostly named operations on mixed-size operands, with a few unused codes.
    // Denominators are zero only now and then.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 31);
      op.func = (r < 30) ? FUNC_W'($urandom_range(FN_ADD, FN_GE))
                         : FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      op.a_num = pick_magnitude(1'b0);
      op.a_den = pick_magnitude($urandom_range(0, 39) != 0);
      op.a_neg = 1'($urandom_range(0, 1));
      op.b_num = pick_magnitude(1'b0);
      op.b_den = pick_magnitude($urandom_range(0, 39) != 0);
      op.b_neg = 1'($urandom_range(0, 1));
      op.drain_first = (i == DRAIN_AT);
      operand_pairs.push_back(op);
    end
    n_items = operand_pairs.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rcvd_cnt < n_items) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && predicted_fractions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d results still expected", $time, mismatches,
               predicted_fractions.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rau_pkg.sv
hdl/rau_reduce.sv
hdl/rational_arithmetic_unit_core.sv
tb/tb_rational_arithmetic_unit_core.sv
